// ----- src/column_post_picture_decoder_core_assert.svh -----
// assertion macros for the column post picture decoder core
// used by column_post_picture_decoder_core, expects clk and rst_n in scope
`ifndef COLUMN_POST_PICTURE_DECODER_CORE_ASSERT_SVH
`define COLUMN_POST_PICTURE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CPPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CPPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cppd_pkg.sv -----
// shared types and codes for the column post picture decoder
// no dependencies
`timescale 1ns / 1ps

package cppd_pkg;

    // default clamps for the size registers
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;

    // request commands
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_PALETTE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    // top-row byte that ends a column
    localparam logic [7:0] END_MARK = 8'hFF;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  column_index;
        logic [7:0]  data_byte;
        logic [23:0] palette_rgb;
    } cppd_req_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [9:0] pixel_x;
        logic [8:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cppd_rsp_t;

    // result event from the parser, colour still to be looked up
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [9:0] x;
        logic [8:0] y;
    } cppd_ev_t;

endpackage

// ----- src/cppd_parser.sv -----
// post stream parser: phase, column, post length and row registers
// depends on cppd_pkg
`timescale 1ns / 1ps

module cppd_parser
    import cppd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  cppd_req_t  req,
    input  logic [10:0] picture_width,
    input  logic [9:0] picture_height,
    output cppd_ev_t   ev
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TOP   = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_PAD_A = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_PAD_B = 3'd5;

    localparam logic [16:0] LIM_W = 17'(MAX_WIDTH);
    localparam logic [16:0] LIM_H = 17'(MAX_HEIGHT);

    logic [2:0] phase_reg, phase_next;
    logic [9:0] col_reg, col_next;
    logic [7:0] top_reg, top_next;
    logic [7:0] left_reg, left_next;
    logic [8:0] row_reg, row_next;
    logic [7:0] left_dec;
    logic       col_ok;
    logic       row_ok;

    // clamp to both the register and the build limit
    assign col_ok = (11'(req.column_index) < picture_width)
                 && (17'(req.column_index) < LIM_W);
    assign row_ok = (10'(row_reg) < picture_height) && (17'(row_reg) < LIM_H);
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        top_next   = top_reg;
        left_next  = left_reg;
        row_next   = row_reg;
        ev         = '0;
        ev.x       = col_reg;
        ev.y       = row_reg;
        if (accept)
        begin
            case (req.command)
                CMD_START:
                begin
                    if (col_ok)
                    begin
                        col_next   = req.column_index;
                        top_next   = '0;
                        left_next  = '0;
                        row_next   = '0;
                        phase_next = PH_TOP;
                    end
                end
                CMD_BYTE:
                begin
                    case (phase_reg)
                        PH_TOP:
                        begin
                            if (req.data_byte == END_MARK)
                            begin
                                phase_next = PH_IDLE;
                                ev.valid   = 1'b1;
                                ev.kind    = KIND_DONE;
                                ev.y       = '0;
                            end
                            else
                            begin
                                top_next   = req.data_byte;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            left_next  = req.data_byte;
                            row_next   = 9'(top_reg);
                            phase_next = PH_PAD_A;
                        end
                        PH_PAD_A:
                        begin
                            phase_next = (left_reg != '0) ? PH_DATA : PH_PAD_B;
                        end
                        PH_DATA:
                        begin
                            ev.valid  = 1'b1;
                            ev.kind   = row_ok ? KIND_PIXEL : KIND_DROP;
                            row_next  = row_reg + 9'd1;
                            left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                phase_next = PH_PAD_B;
                            end
                        end
                        PH_PAD_B:
                        begin
                            phase_next = PH_TOP;
                        end
                        default:
                        begin
                            // idle: stream bytes are ignored
                        end
                    endcase
                end
                default:
                begin
                    // palette writes and unknown commands leave the parse state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            col_reg   <= '0;
            top_reg   <= '0;
            left_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            top_reg   <= top_next;
            left_reg  <= left_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ----- src/column_post_picture_decoder_core.sv -----
// column post picture decoder: top level with palette memory, result pipeline, apb registers
// depends on cppd_pkg, cppd_parser and column_post_picture_decoder_core_assert.svh
//
// usage
//   request channel (req_valid/req_stall/req) carries one command per request:
//   start column, column stream byte, or palette entry write
//   response channel (rsp_valid/rsp_stall/rsp) carries pixel writes, dropped
//   pixels below the picture height and column-finished markers
//   apb port: picture_width at byte address 0, picture_height at address 4
// throughput: one request per cycle while req_stall is low; the palette memory has one write
//   and one read port, the read being issued in the cycle a request is accepted
// response path: an accepted request is registered in the palette read stage, then
//   in the output register, where its response is valid
// stall: the palette stage and the output register form a two-deep buffer, so
//   one more request is taken while a response waits; req_stall rises only
//   when both hold a response and rsp_stall is high
// reset: parse state goes idle, size registers return to 1024 and 512;
//   palette contents are undefined until written
`timescale 1ns / 1ps
`include "column_post_picture_decoder_core_assert.svh"

module column_post_picture_decoder_core
    import cppd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  cppd_req_t   req,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output cppd_rsp_t   rsp,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // size registers
    logic [10:0] width_reg;
    logic [9:0]  height_reg;
    logic        cfg_wr;

    // pipeline
    logic        accept;
    logic        s1_move;
    cppd_ev_t    ev;
    cppd_ev_t    s1_reg, s1_next;
    cppd_rsp_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [23:0] colour;

    // palette memory, one write and one registered read per cycle
    logic [23:0] palette_mem [256];
    logic [23:0] rdata_reg;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 10'd512;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[9:0];
                default:    ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // palette stage advances when the output register is empty or being drained
    assign s1_move   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = s1_reg.valid && !s1_move;
    assign accept    = req_valid && !req_stall;

    // ---------------- parser ----------------
    cppd_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req            (req),
        .picture_width  (width_reg),
        .picture_height (height_reg),
        .ev             (ev)
    );

    // ---------------- palette memory ----------------
    // one request per edge, and only a palette write reads and writes at the same edge with
    // its own read result unused, so a lookup always sees every earlier palette write
    always_ff @(posedge clk)
    begin
        if (accept && (req.command == CMD_PALETTE))
        begin
            palette_mem[req.data_byte] <= req.palette_rgb;
        end
        if (accept)
        begin
            rdata_reg <= palette_mem[req.data_byte];
        end
    end

    // ---------------- palette stage ----------------
    always_comb
    begin
        if (accept)
        begin
            s1_next = ev;
        end
        else if (s1_move)
        begin
            s1_next       = s1_reg;
            s1_next.valid = 1'b0;
        end
        else
        begin
            s1_next = s1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- output register ----------------
    // only a pixel write carries a colour; drops and column ends send zero
    assign colour = (s1_reg.kind == KIND_PIXEL) ? rdata_reg : '0;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (s1_move)
        begin
            rsp_valid_next       = s1_reg.valid;
            rsp_next.result_kind = s1_reg.kind;
            rsp_next.pixel_x     = s1_reg.x;
            rsp_next.pixel_y     = s1_reg.y;
            rsp_next.red         = colour[23:16];
            rsp_next.green       = colour[15:8];
            rsp_next.blue        = colour[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    `CPPD_ASSERT_NOW(a_no_colour_unless_pixel,
        rsp_valid && (rsp.result_kind != KIND_PIXEL),
        (rsp.red == 8'd0) && (rsp.green == 8'd0) && (rsp.blue == 8'd0),
        "non-pixel response carries a colour")
    `CPPD_ASSERT_NOW(a_done_row_zero,
        rsp_valid && (rsp.result_kind == KIND_DONE),
        rsp.pixel_y == 9'd0,
        "column-finished response with nonzero row")
    `CPPD_ASSERT_NOW(a_pixel_in_height,
        rsp_valid && (rsp.result_kind == KIND_PIXEL),
        10'(rsp.pixel_y) < height_reg,
        "pixel write at or beyond picture height")
    `CPPD_ASSERT_NEXT(a_stage_held_on_stall,
        s1_reg.valid && rsp_valid_reg && rsp_stall,
        s1_reg.valid && rsp_valid_reg,
        "buffered response lost during stall")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// testbench for column_post_picture_decoder_core: drives column streams, palette loads
// and size register writes, predicts every response in order and checks each field
// depends on cppd_pkg and the decoder rtl under src

module tb;
    import cppd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 6;       // palette stage and output register plus margin
    localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
    localparam int LIMIT_CYCLES = 300000;
    localparam int PHASE_ITEMS  = 150;     // effective requests per idling phase
    localparam int SIZE_COLUMNS = 6;       // random columns per size setting

    // command code the block does not know
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TOP,
        PH_LEN,
        PH_PAD_A,
        PH_DATA,
        PH_PAD_B
    } parse_phase_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    cppd_req_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    cppd_rsp_t   rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    column_post_picture_decoder_core uut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // decoder state as the testbench sees it
    parse_phase_e dec_phase  = PH_IDLE;
    logic [9:0]   dec_column = '0;
    logic [7:0]   dec_top    = '0;
    logic [7:0]   dec_left   = '0;
    logic [8:0]   dec_row    = '0;
    logic [23:0]  colour_table [256];
    logic [10:0]  cfg_width  = 11'd1024;
    logic [9:0]   cfg_height = 10'd512;

    // responses still owed by the block, oldest first
    cppd_rsp_t pixel_events_due [$];

    int error_count   = 0;
    int items_taken   = 0;   // requests that changed decoder state
    int send_idle_pct = 0;
    int rcv_stall_pct = 0;

    logic stall_burst_on = 1'b0;
    event stall_burst_ev;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // width register clamped to the build-time maximum
    function automatic int eff_width();
        return (cfg_width < DEF_MAX_WIDTH) ? int'(cfg_width) : DEF_MAX_WIDTH;
    endfunction

    // advance the decoder by one accepted request, queue its response if any;
    // returns 0 when the request was ignored
    function automatic bit column_decode(cppd_req_t r);
        cppd_rsp_t res;
        int        eff_h;
        bit        has_res;
        bit        took;
        res     = '0;
        has_res = 1'b0;
        took    = 1'b1;
        eff_h   = (cfg_height < DEF_MAX_HEIGHT) ? int'(cfg_height) : DEF_MAX_HEIGHT;
        case (r.command)
            CMD_START:
            begin
                // out-of-range start leaves everything untouched
                if (r.column_index < eff_width())
                begin
                    dec_column = r.column_index;
                    dec_top    = '0;
                    dec_left   = '0;
                    dec_row    = '0;
                    dec_phase  = PH_TOP;
                end
                else
                    took = 1'b0;
            end
            CMD_PALETTE:
                colour_table[r.data_byte] = r.palette_rgb;
            CMD_BYTE:
            begin
                case (dec_phase)
                    PH_TOP:
                    begin
                        if (r.data_byte == END_MARK)
                        begin
                            dec_phase       = PH_IDLE;
                            res.result_kind = KIND_DONE;
                            res.pixel_x     = dec_column;
                            has_res         = 1'b1;
                        end
                        else
                        begin
                            dec_top   = r.data_byte;
                            dec_phase = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        dec_left  = r.data_byte;
                        dec_row   = {1'b0, dec_top};
                        dec_phase = PH_PAD_A;
                    end
                    PH_PAD_A:
                        dec_phase = (dec_left != 0) ? PH_DATA : PH_PAD_B;
                    PH_DATA:
                    begin
                        res.pixel_x = dec_column;
                        res.pixel_y = dec_row;
                        if (dec_row < eff_h)
                        begin
                            res.result_kind = KIND_PIXEL;
                            {res.red, res.green, res.blue} = colour_table[r.data_byte];
                        end
                        else
                            res.result_kind = KIND_DROP;
                        has_res  = 1'b1;
                        dec_row  = dec_row + 9'd1;
                        dec_left = dec_left - 8'd1;
                        if (dec_left == 0)
                            dec_phase = PH_PAD_B;
                    end
                    PH_PAD_B:
                        dec_phase = PH_TOP;
                    default:
                        took = 1'b0;   // stream byte while idle
                endcase
            end
            default:
                took = 1'b0;
        endcase
        if (has_res)
            pixel_events_due.push_back(res);
        return took;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        error_count++;
        // keep the log short when something is badly broken
        if (error_count <= 100)
            $display("tb: mismatch at %0t ns: %s", $realtime, msg);
    endtask

    // every accepted response is matched against the oldest prediction
    always @(posedge clk)
    begin : check_responses
        cppd_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pixel_events_due.size() == 0)
                report_mismatch($sformatf("unexpected response %h", rsp));
            else
            begin
                want = pixel_events_due.pop_front();
                if (rsp.result_kind !== want.result_kind)
                    report_mismatch($sformatf("result_kind got %0d want %0d",
                                              rsp.result_kind, want.result_kind));
                if (rsp.pixel_x !== want.pixel_x)
                    report_mismatch($sformatf("pixel_x got %0d want %0d",
                                              rsp.pixel_x, want.pixel_x));
                if (rsp.pixel_y !== want.pixel_y)
                    report_mismatch($sformatf("pixel_y got %0d want %0d",
                                              rsp.pixel_y, want.pixel_y));
                if (rsp.red !== want.red)
                    report_mismatch($sformatf("red got %h want %h", rsp.red, want.red));
                if (rsp.green !== want.green)
                    report_mismatch($sformatf("green got %h want %h", rsp.green, want.green));
                if (rsp.blue !== want.blue)
                    report_mismatch($sformatf("blue got %h want %h", rsp.blue, want.blue));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------

    // random stall, forced high during a hold-off burst
    always @(posedge clk)
    begin
        rsp_stall <= stall_burst_on || ($urandom_range(0, 99) < rcv_stall_pct);
    end

    // long hold-off, counted here so the sender keeps going meanwhile
    initial
    begin
        forever
        begin
            @(stall_burst_ev);
            stall_burst_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            stall_burst_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one request, hold it until taken, then maybe go idle a while
    task automatic push_item(logic [1:0] cmd, logic [9:0] col, logic [7:0] b,
                             logic [23:0] rgb);
        cppd_req_t r;
        r.command      = cmd;
        r.column_index = col;
        r.data_byte    = b;
        r.palette_rgb  = rgb;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (column_decode(r))
            items_taken++;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stream byte, unused fields filled with noise
    task automatic push_byte(logic [7:0] b);
        push_item(CMD_BYTE, 10'($urandom), b, 24'($urandom));
    endtask

    // one well-formed post: top, length, pad, indices, pad
    task automatic send_post(logic [7:0] top, logic [7:0] len);
        push_byte(top);
        push_byte(len);
        push_byte(8'($urandom));
        for (int j = 0; j < len; j++)
            push_byte(8'($urandom));
        push_byte(8'($urandom));
    endtask

    // start a column and feed a few posts; noise requests and truncated
    // columns appear at the given rate
    task automatic random_column(int noise_pct);
        int         ew;
        int         nposts;
        logic [9:0] col;
        logic [7:0] top;
        logic [7:0] len;
        ew = eff_width();
        if (ew > 0 && $urandom_range(0, 9) != 0)
            col = 10'($urandom_range(0, ew - 1));
        else
            col = 10'($urandom);
        push_item(CMD_START, col, 8'($urandom), 24'($urandom));
        nposts = $urandom_range(0, 3);
        for (int p = 0; p < nposts; p++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                push_item(2'($urandom), 10'($urandom), 8'($urandom), 24'($urandom));
            // mostly shallow posts, now and then anywhere in the column
            top = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 40))
                                               : 8'($urandom_range(0, 254));
            // rare full-length posts keep the run short
            len = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 6));
            send_post(top, len);
        end
        // a missing end mark leaves the column open for a restart
        if ($urandom_range(0, 99) >= noise_pct)
            push_byte(END_MARK);
    endtask

    // sender quiet until every owed response is in, then let the pipe empty
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pixel_events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    // setup and access phase, then return to idle with psel low
    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_size_reg(logic idx, logic [31:0] want);
        logic [31:0] got;
        apb_xfer(1'b0, {idx, 2'b00}, '0, got);
        if (got !== want)
            report_mismatch($sformatf("register %0d reads %0d want %0d", idx, got, want));
    endtask

    task automatic write_size_reg(logic idx, logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(1'b1, {idx, 2'b00}, value, unused);
        if (idx == REG_WIDTH)
            cfg_width = value[10:0];
        else
            cfg_height = value[9:0];
        check_size_reg(idx, value);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_reset_registers();
        check_size_reg(REG_WIDTH, 32'd1024);
        check_size_reg(REG_HEIGHT, 32'd512);
    endtask

    // every palette entry gets a colour before any index is used
    task automatic test_palette_load();
        logic [23:0] rgb;
        for (int i = 0; i < 256; i++)
        begin
            if (i == 0)
                rgb = '0;
            else if (i == 255)
                rgb = '1;
            else
                rgb = 24'($urandom);
            push_item(CMD_PALETTE, 10'($urandom), 8'(i), rgb);
        end
    endtask

    task automatic test_directed_columns();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        // stream byte while idle and unknown command, both ignored
        push_byte(8'h00);
        push_item(CMD_UNUSED, 10'h3FF, 8'hFF, 24'hFFFFFF);
        // empty column
        push_item(CMD_START, 10'd0, 8'h00, 24'h000000);
        push_byte(END_MARK);
        // last column, one pixel at the top row with index zero
        push_item(CMD_START, 10'd1023, 8'h00, 24'h000000);
        push_byte(8'd0);
        push_byte(8'd1);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        // zero-length post
        push_byte(8'd5);
        push_byte(8'd0);
        push_byte(8'hFF);
        push_byte(8'h00);
        // deepest top row, palette rewritten between the two pixels
        push_byte(8'd254);
        push_byte(8'd2);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_item(CMD_PALETTE, 10'd0, 8'hFF, 24'h5A00A5);
        push_byte(8'hFF);
        push_byte(8'hFF);
        // restart in the middle of a post header
        push_byte(8'd7);
        push_item(CMD_START, 10'd6, 8'h00, 24'h000000);
        push_byte(END_MARK);
    endtask

    // size registers through their extremes, a short random run at each
    task automatic test_size_settings();
        int unsigned widths  [6];
        int unsigned heights [6];
        widths  = '{0, 1, 2047, 16, 0, 1024};
        heights = '{512, 1, 0, 1023, 0, 512};
        widths[4]  = $urandom_range(1, 2047);
        heights[4] = $urandom_range(1, 1023);
        send_idle_pct = 20;
        rcv_stall_pct = 20;
        for (int k = 0; k < 6; k++)
        begin
            wait_drained();
            write_size_reg(REG_WIDTH, widths[k]);
            write_size_reg(REG_HEIGHT, heights[k]);
            for (int c = 0; c < SIZE_COLUMNS; c++)
                random_column(10);
        end
    endtask

    // no idling, idle sender, stalling receiver, both
    task automatic test_idle_patterns();
        int send_pcts [4];
        int rcv_pcts  [4];
        int start_count;
        send_pcts = '{0, 46, 0, 30};
        rcv_pcts  = '{0, 0, 46, 30};
        for (int k = 0; k < 4; k++)
        begin
            send_idle_pct = send_pcts[k];
            rcv_stall_pct = rcv_pcts[k];
            start_count   = items_taken;
            while (items_taken - start_count < PHASE_ITEMS)
                random_column(15);
        end
    endtask

    // receiver holds off while a long post streams in, so the block has to
    // stall its input; then the sender waits for every response and a stalling run follows
    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        -> stall_burst_ev;
        push_item(CMD_START, 10'd3, 8'h00, 24'h000000);
        send_post(8'd10, 8'd80);
        push_byte(END_MARK);
        wait_drained();
        rcv_stall_pct = 46;
        for (int c = 0; c < 6; c++)
            random_column(10);
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_registers();
        test_palette_load();
        test_directed_columns();
        test_size_settings();
        test_idle_patterns();
        test_backpressure();
        wait_drained();
        if (pixel_events_due.size() != 0)
            report_mismatch($sformatf("%0d responses never came", pixel_events_due.size()));
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- column_post_picture_decoder_core.f -----
+incdir+src
src/cppd_pkg.sv
src/cppd_parser.sv
src/column_post_picture_decoder_core.sv
dv/tb.sv
